@@ rtl/chbi_pkg.sv @@
package chbi_pkg;

	localparam int unsigned MAX_BUCKETS_DEF = 512;
	localparam int unsigned MAX_SLOTS_DEF   = 256;
	localparam int unsigned POOLS_DEF       = 2;

	localparam int unsigned CMD_W    = 2;
	localparam int unsigned VOL_W    = 16;
	localparam int unsigned PAGE_W   = 31;
	localparam int unsigned SLOTIN_W = 8;
	localparam int unsigned KEY_W    = VOL_W + PAGE_W;
	localparam int unsigned BCFG_W   = 10;
	localparam int unsigned SCFG_W   = 9;
	localparam int unsigned CFG_W    = 10;
	localparam int unsigned STATUS_W = 2;

	typedef enum logic [1:0] {
		CMD_LOOKUP = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_DELETE = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_SLOT  = 2'd1,
		ST_NOT_FOUND = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		REG_BUCKETS_POOL0 = 2'd0,
		REG_BUCKETS_POOL1 = 2'd1,
		REG_SLOTS_POOL0   = 2'd2,
		REG_SLOTS_POOL1   = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLEAR,
		S_MOD,
		S_HEAD_RD,
		S_HEAD_WAIT,
		S_CHECK,
		S_LINK_WAIT,
		S_UNLINK,
		S_DONE
	} state_t;

endpackage

@@ rtl/chained_hash_buffer_index.sv @@
// chained_hash_buffer_index
// Maps a page key (vol_no, page_no) to a buffer slot through a hash table
// with separate chaining, one table per buffer pool.
// Channels: s_axis carries one command per transaction (lookup, insert,
// delete, clear); m_axis returns exactly one result (status, found_slot)
// per command, in order. cfg_we/cfg_idx/cfg_data write the bucket and slot
// counts of each pool; write them only while the block is idle.
// Hashing: the bucket index is (vol+page) mod bucket count, reduced by a
// restoring divider one quotient bit per cycle over the 32-bit sum. Then
// the bucket head is read, and each chain link is checked with the key and
// link memories read in parallel.
// Insert: a rejected slot skips the divider and goes straight to the result.
// Lookup/delete: the walk follows the chain link by link; a delete that
// hits also unlinks the entry. Clear sweeps the bucket heads one entry per cycle.
// One command is in flight at a time; s_axis_tready is high only in idle,
// the cycle after the previous result has been loaded into the output register.
// Reset: all bucket heads are marked empty by a clearing pass over all
// POOLS*MAX_BUCKETS entries after arst_n releases; no command is taken
// meanwhile and no result is produced. Config resets to 512 buckets, 256 slots.
// Stall: a result waits in the output register while m_axis_tready is low.
module chained_hash_buffer_index #(
	parameter int unsigned MAX_BUCKETS = chbi_pkg::MAX_BUCKETS_DEF,
	parameter int unsigned MAX_SLOTS   = chbi_pkg::MAX_SLOTS_DEF,
	parameter int unsigned POOLS       = chbi_pkg::POOLS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_idx,
	input  logic [chbi_pkg::CFG_W-1:0] cfg_data,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	// command[1:0], pool[2], vol_no[18:3], page_no[49:19], slot_index[57:50]
	input  logic [63:0]               s_axis_tdata,
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	// status[1:0], found_slot[9:2]
	output logic [15:0]               m_axis_tdata
);
	import chbi_pkg::*;

	localparam int unsigned PW   = (POOLS > 1) ? $clog2(POOLS) : 1;
	localparam int unsigned BW   = $clog2(MAX_BUCKETS);
	localparam int unsigned SW   = $clog2(MAX_SLOTS);
	localparam int unsigned HD   = POOLS * MAX_BUCKETS;
	localparam int unsigned LD   = POOLS * MAX_SLOTS;
	localparam int unsigned HAW  = (HD > 1) ? $clog2(HD) : 1;
	localparam int unsigned LAW  = (LD > 1) ? $clog2(LD) : 1;
	localparam int unsigned LNKW = SW + 1;          // msb = empty mark
	localparam int unsigned SUMW = PAGE_W + 1;
	localparam int unsigned CNTW = $clog2(SUMW + 1);

	// memories
	logic [LNKW-1:0]  head_mem [HD];
	logic [LNKW-1:0]  link_mem [LD];
	logic [KEY_W-1:0] key_mem  [LD];

	// config
	logic [BCFG_W-1:0] bkt_q [2];
	logic [SCFG_W-1:0] slt_q [2];

	state_t state_q, state_d;
	logic   init_q;         // clearing pass after reset, no result

	// command registers
	cmd_t             cmd_q;
	logic [PW-1:0]    pool_q;
	logic             pool_ok_q;
	logic [KEY_W-1:0] key_q;
	logic [SW-1:0]    slot_q;
	logic             slot_ok_q;
	logic [HAW-1:0]   clr_q;
	logic [SUMW-1:0]  rem_q;
	logic [SUMW-1:0]  dvd_q;
	logic [CNTW-1:0]  bit_q;
	logic [BW:0]      div_q;
	logic [HAW-1:0]   hb_q;
	logic [LNKW-1:0]  cur_q;
	logic [SW-1:0]    prev_q;
	logic             has_prev_q;
	logic [SW:0]      steps_q;
	logic             hit_q;

	// memory read data
	logic [LNKW-1:0]  head_rd_q;
	logic [LNKW-1:0]  link_rd_q;
	logic [KEY_W-1:0] key_rd_q;

	// output register
	logic             ov_q;
	status_t          ost_q;
	logic [7:0]       oslot_q;

	// input decode
	logic [1:0]        in_cmd;
	logic              in_pool;
	logic [VOL_W-1:0]  in_vol;
	logic [PAGE_W-1:0] in_page;
	logic [7:0]        in_slot;
	assign in_cmd  = s_axis_tdata[1:0];
	assign in_pool = s_axis_tdata[2];
	assign in_vol  = s_axis_tdata[18:3];
	assign in_page = s_axis_tdata[49:19];
	assign in_slot = s_axis_tdata[57:50];

	logic accept;
	assign s_axis_tready = (state_q == S_IDLE);
	assign accept = s_axis_tvalid && s_axis_tready;

	// effective counts for the incoming pool
	logic [BCFG_W-1:0] b_raw;
	logic [BW:0]       b_eff;
	logic [SCFG_W-1:0] s_raw;
	logic [SW:0]       s_eff;
	logic [8:0]        slot_ext;
	always_comb begin
		b_raw = bkt_q[in_pool];
		s_raw = slt_q[in_pool];
		if (b_raw == '0)
			b_eff = (BW+1)'(1);
		else if (32'(b_raw) > MAX_BUCKETS)
			b_eff = (BW+1)'(MAX_BUCKETS);
		else
			b_eff = (BW+1)'(b_raw);
		if (32'(s_raw) > MAX_SLOTS)
			s_eff = (SW+1)'(MAX_SLOTS);
		else
			s_eff = (SW+1)'(s_raw);
		slot_ext = {1'b0, in_slot};
	end

	// restoring mod step
	logic [SUMW:0] trial;
	logic [SUMW:0] shifted;
	always_comb begin
		shifted = {rem_q, dvd_q[SUMW-1]};
		trial   = shifted - (SUMW+1)'(div_q);
	end

	logic           hit;
	logic           cur_end;
	logic [LAW-1:0] cur_addr;
	logic [LAW-1:0] prev_addr;
	logic [LAW-1:0] slot_addr;
	assign hit       = (key_rd_q == key_q);
	assign cur_end   = cur_q[LNKW-1] || (steps_q == (SW+1)'(MAX_SLOTS));
	assign cur_addr  = LAW'(32'(pool_q) * MAX_SLOTS + 32'(cur_q[SW-1:0]));
	assign prev_addr = LAW'(32'(pool_q) * MAX_SLOTS + 32'(prev_q));
	assign slot_addr = LAW'(32'(pool_q) * MAX_SLOTS + 32'(slot_q));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept)
					state_d = (cmd_t'(in_cmd) == CMD_CLEAR) ? S_CLEAR : S_MOD;
			end
			S_CLEAR: begin
				if (clr_q == HAW'(HD - 1))
					state_d = init_q ? S_IDLE : S_DONE;
			end
			S_MOD: begin
				if (!pool_ok_q || (cmd_q == CMD_INSERT && !slot_ok_q))
					state_d = S_DONE;
				else if (bit_q == '0)
					state_d = S_HEAD_RD;
			end
			S_HEAD_RD:   state_d = S_HEAD_WAIT;
			S_HEAD_WAIT: state_d = (cmd_q == CMD_INSERT) ? S_DONE : S_CHECK;
			S_CHECK: begin
				if (cur_end)
					state_d = S_DONE;
				else
					state_d = S_LINK_WAIT;
			end
			S_LINK_WAIT: begin
				if (hit)
					state_d = (cmd_q == CMD_LOOKUP) ? S_DONE : S_UNLINK;
				else
					state_d = S_CHECK;
			end
			S_UNLINK: state_d = S_DONE;
			S_DONE: begin
				if (!ov_q || m_axis_tready)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	logic done_load;
	assign done_load = (state_q == S_DONE) && (!ov_q || m_axis_tready);
	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata  = {6'd0, oslot_q, ost_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			init_q  <= 1'b1;
			clr_q   <= '0;
			ov_q    <= 1'b0;
			bkt_q[0] <= BCFG_W'(512);
			bkt_q[1] <= BCFG_W'(512);
			slt_q[0] <= SCFG_W'(256);
			slt_q[1] <= SCFG_W'(256);
			ost_q   <= ST_OK;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR && clr_q == HAW'(HD - 1))
				init_q <= 1'b0;
			if (cfg_we) begin
				case (reg_idx_t'(cfg_idx))
					REG_BUCKETS_POOL0: bkt_q[0] <= cfg_data[BCFG_W-1:0];
					REG_BUCKETS_POOL1: bkt_q[1] <= cfg_data[BCFG_W-1:0];
					REG_SLOTS_POOL0:   slt_q[0] <= cfg_data[SCFG_W-1:0];
					REG_SLOTS_POOL1:   slt_q[1] <= cfg_data[SCFG_W-1:0];
					default: ;
				endcase
			end
			if (state_q == S_CLEAR)
				clr_q <= clr_q + HAW'(1);
			else
				clr_q <= '0;
			if (done_load)
				ov_q <= 1'b1;
			else if (m_axis_tvalid && m_axis_tready)
				ov_q <= 1'b0;
			if (done_load) begin
				if (cmd_q == CMD_CLEAR)
					ost_q <= ST_OK;
				else if (!pool_ok_q)
					ost_q <= (cmd_q == CMD_INSERT) ? ST_BAD_SLOT : ST_NOT_FOUND;
				else if (cmd_q == CMD_INSERT)
					ost_q <= slot_ok_q ? ST_OK : ST_BAD_SLOT;
				else
					ost_q <= has_prev_q || hit_q ? (hit_q ? ST_OK : ST_NOT_FOUND)
						: ST_NOT_FOUND;
			end
		end
	end

	// hit flag of the finished walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hit_q <= 1'b0;
		else if (accept)
			hit_q <= 1'b0;
		else if (state_q == S_LINK_WAIT && hit)
			hit_q <= 1'b1;
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q      <= cmd_t'(in_cmd);
			pool_q     <= PW'(in_pool);
			pool_ok_q  <= (32'(in_pool) < POOLS);
			key_q      <= {in_vol, in_page};
			slot_q     <= SW'(in_slot);
			slot_ok_q  <= ({1'b0, slot_ext} < 10'(s_eff));
			rem_q      <= '0;
			dvd_q      <= SUMW'(in_vol) + SUMW'(in_page);
			bit_q      <= CNTW'(SUMW);
			div_q      <= b_eff;
			has_prev_q <= 1'b0;
			steps_q    <= '0;
		end
		if (state_q == S_MOD && bit_q != '0) begin
			rem_q <= trial[SUMW] ? shifted[SUMW-1:0] : trial[SUMW-1:0];
			dvd_q <= {dvd_q[SUMW-2:0], 1'b0};
			bit_q <= bit_q - CNTW'(1);
		end
		if (state_q == S_HEAD_RD)
			hb_q <= HAW'(32'(pool_q) * MAX_BUCKETS + 32'(rem_q[BW-1:0]));
		if (state_q == S_HEAD_WAIT)
			cur_q <= head_rd_q;
		if (state_q == S_LINK_WAIT && !hit) begin
			prev_q     <= cur_q[SW-1:0];
			has_prev_q <= 1'b1;
			cur_q      <= link_rd_q;
			steps_q    <= steps_q + (SW+1)'(1);
		end
		if (done_load)
			oslot_q <= (cmd_q == CMD_LOOKUP && pool_ok_q && hit_q) ?
				8'(cur_q[SW-1:0]) : 8'd0;
	end

	// bucket head memory: one read port, one write port
	logic [HAW-1:0] head_raddr;
	assign head_raddr = HAW'(32'(pool_q) * MAX_BUCKETS + 32'(rem_q[BW-1:0]));
	always_ff @(posedge clk) begin
		if (state_q == S_HEAD_RD)
			head_rd_q <= head_mem[head_raddr];
		if (state_q == S_CLEAR)
			head_mem[clr_q] <= {1'b1, {SW{1'b0}}};
		else if (state_q == S_HEAD_WAIT && cmd_q == CMD_INSERT)
			head_mem[hb_q] <= {1'b0, slot_q};
		else if (state_q == S_UNLINK && !has_prev_q)
			head_mem[hb_q] <= link_rd_q;
	end

	// link and key memories
	always_ff @(posedge clk) begin
		if (state_q == S_CHECK) begin
			link_rd_q <= link_mem[cur_addr];
			key_rd_q  <= key_mem[cur_addr];
		end
		if (state_q == S_HEAD_WAIT && cmd_q == CMD_INSERT) begin
			link_mem[slot_addr] <= head_rd_q;
			key_mem[slot_addr]  <= key_q;
		end else if (state_q == S_UNLINK && has_prev_q) begin
			link_mem[prev_addr] <= link_rd_q;
		end
	end

endmodule

@@ bench/chbi_checker.sv @@
`timescale 1ns / 1ps

module chbi_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_idx,
	input  logic [chbi_pkg::CFG_W-1:0] cfg_data,
	input  logic                       s_tvalid,
	input  logic                       s_tready,
	input  logic [63:0]                s_tdata,
	input  logic                       m_tvalid,
	input  logic                       m_tready,
	input  logic [15:0]                m_tdata,
	output int                         fails,
	output int                         pending
);
	import chbi_pkg::*;

	localparam int NB = MAX_BUCKETS_DEF;
	localparam int NS = MAX_SLOTS_DEF;
	localparam logic [15:0] HEAD_EMPTY = 16'h8000;

	typedef struct packed {
		status_t    st;
		logic [7:0] slot;
	} answer_t;

	answer_t answers_due[$];

	logic [15:0]      heads   [POOLS_DEF*NB];
	logic [15:0]      links   [POOLS_DEF*NS];
	logic [KEY_W-1:0] keys    [POOLS_DEF*NS];
	logic [BCFG_W-1:0] nbuck  [2];
	logic [SCFG_W-1:0] nslot  [2];

	assign pending = answers_due.size();

	task automatic index_apply(input logic [63:0] d, output answer_t a);
		cmd_t             cmd;
		logic             pl;
		logic [VOL_W-1:0] vol;
		logic [PAGE_W-1:0] page;
		logic [7:0]       sl;
		logic [KEY_W-1:0] key;
		int unsigned      b, s, hb, sb, cur, prv, steps;
		bit               has_prv, hit;
		cmd  = cmd_t'(d[1:0]);
		pl   = d[2];
		vol  = d[18:3];
		page = d[49:19];
		sl   = d[57:50];
		key  = {vol, page};
		a.st = ST_OK;
		a.slot = '0;
		if (cmd == CMD_CLEAR) begin
			foreach (heads[i]) heads[i] = HEAD_EMPTY;
		end else begin
			b = 32'(nbuck[pl]);
			if (b == 0) b = 1;
			if (b > NB) b = NB;
			s = 32'(nslot[pl]);
			if (s > NS) s = NS;
			hb = pl * NB + ((32'(vol) + 32'(page)) % b);
			sb = pl * NS;
			if (cmd == CMD_INSERT) begin
				if (sl >= s) a.st = ST_BAD_SLOT;
				else begin
					links[sb + sl] = heads[hb];
					keys[sb + sl]  = key;
					heads[hb]      = 16'(sl);
				end
			end else begin
				cur = 32'(heads[hb]);
				prv = 0;
				has_prv = 0;
				hit = 0;
				for (steps = 0; steps < NS; steps++) begin
					if (cur[15] || cur >= NS) break;
					if (keys[sb + cur] == key) begin
						hit = 1;
						break;
					end
					prv = cur;
					has_prv = 1;
					cur = 32'(links[sb + cur]);
				end
				if (!hit) a.st = ST_NOT_FOUND;
				else if (cmd == CMD_LOOKUP) a.slot = cur[7:0];
				else if (has_prv) links[sb + prv] = links[sb + cur];
				else heads[hb] = links[sb + cur];
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		answer_t want, got;
		if (!arst_n) begin
			foreach (heads[i]) heads[i] = HEAD_EMPTY;
			foreach (links[i]) links[i] = '0;
			foreach (keys[i]) keys[i] = '0;
			nbuck[0] = 10'd512;
			nbuck[1] = 10'd512;
			nslot[0] = 9'd256;
			nslot[1] = 9'd256;
			answers_due.delete();
			fails = 0;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_idx))
					REG_BUCKETS_POOL0: nbuck[0] = cfg_data[BCFG_W-1:0];
					REG_BUCKETS_POOL1: nbuck[1] = cfg_data[BCFG_W-1:0];
					REG_SLOTS_POOL0:   nslot[0] = cfg_data[SCFG_W-1:0];
					REG_SLOTS_POOL1:   nslot[1] = cfg_data[SCFG_W-1:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got.st = status_t'(m_tdata[1:0]);
				got.slot = m_tdata[9:2];
				if (answers_due.size() == 0) begin
					$display("%0t: unexpected result status=%0d slot=%0d",
						$realtime, got.st, got.slot);
					fails++;
				end else begin
					want = answers_due.pop_front();
					if (got.st !== want.st) begin
						$display("%0t: status expected %0d actual %0d",
							$realtime, want.st, got.st);
						fails++;
					end
					if (got.slot !== want.slot) begin
						$display("%0t: found_slot expected %0d actual %0d",
							$realtime, want.slot, got.slot);
						fails++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				index_apply(s_tdata, want);
				answers_due.push_back(want);
			end
		end
	end

endmodule

@@ bench/tb_chained_hash_buffer_index.sv @@
`timescale 1ns / 1ps

module tb_chained_hash_buffer_index;
	import chbi_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [1:0]       cfg_idx;
	logic [CFG_W-1:0] cfg_data;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	logic [63:0]      s_axis_tdata;
	logic             m_axis_tvalid;
	logic             m_axis_tready;
	logic [15:0]      m_axis_tdata;
	int               fails;
	int               pending;
	int               cycles;
	int               sent_by_cmd [4];
	bit               calm;          // no idling on either side when set

	// recently inserted keys, reused so lookups and deletes actually hit
	logic [VOL_W+PAGE_W-1:0] known_keys[$];
	int unsigned             slot_cap [2];

	chained_hash_buffer_index u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	chbi_checker u_chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.s_tvalid (s_axis_tvalid),
		.s_tready (s_axis_tready),
		.s_tdata  (s_axis_tdata),
		.m_tvalid (m_axis_tvalid),
		.m_tready (m_axis_tready),
		.m_tdata  (m_axis_tdata),
		.fails    (fails),
		.pending  (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// watchdog
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// mostly short gaps, a few long ones
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// result side backpressure, changed at the falling edge
	initial begin
		int unsigned g;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			m_axis_tready <= 1'b1;
			repeat ($urandom_range(0, 6)) @(negedge clk);
			g = pick_gap();
			if (g > 0) begin
				m_axis_tready <= 1'b0;
				repeat (g - 1) @(negedge clk);
			end
		end
	end

	// one command transaction; valid only drops when a gap follows
	task automatic send_cmd(input cmd_t c, input logic p, input logic [15:0] v,
			input logic [30:0] pg, input logic [7:0] sl);
		int unsigned g;
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {6'b0, sl, pg, v, p, c};
		do @(posedge clk); while (!s_axis_tready);
		sent_by_cmd[c]++;
		if (c == CMD_INSERT) begin
			known_keys.push_back({v, pg});
			if (known_keys.size() > 24) void'(known_keys.pop_front());
		end
		g = pick_gap();
		if (g > 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (g - 1) @(negedge clk);
		end
	endtask

	// stop sending, drain, let the block settle, then write one register
	task automatic write_reg(input reg_idx_t r, input logic [CFG_W-1:0] val);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (20) @(negedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= r;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (r == REG_SLOTS_POOL0) slot_cap[0] = (val[8:0] > 256) ? 256 : 32'(val[8:0]);
		if (r == REG_SLOTS_POOL1) slot_cap[1] = (val[8:0] > 256) ? 256 : 32'(val[8:0]);
	endtask

	task automatic set_pools(input int b0, input int b1, input int s0, input int s1);
		write_reg(REG_BUCKETS_POOL0, CFG_W'(b0));
		write_reg(REG_BUCKETS_POOL1, CFG_W'(b1));
		write_reg(REG_SLOTS_POOL0, CFG_W'(s0));
		write_reg(REG_SLOTS_POOL1, CFG_W'(s1));
	endtask

	task automatic random_cmd();
		int unsigned r;
		cmd_t        c;
		logic        p;
		logic [46:0] k;
		logic [7:0]  sl;
		r = $urandom_range(0, 99);
		if (r < 38) c = CMD_INSERT;
		else if (r < 70) c = CMD_LOOKUP;
		else if (r < 97) c = CMD_DELETE;
		else c = CMD_CLEAR;
		p = 1'($urandom_range(0, 1));
		if (known_keys.size() > 0 && c != CMD_INSERT && $urandom_range(0, 99) < 70)
			k = known_keys[$urandom_range(0, known_keys.size() - 1)];
		else if ($urandom_range(0, 3) == 0)
			k = {16'($urandom_range(0, 3)), 31'($urandom_range(0, 40))};
		else
			k = {16'($urandom), 31'($urandom)};
		// mostly legal slots, sometimes anything at all
		if ($urandom_range(0, 9) == 0 || slot_cap[p] == 0) sl = 8'($urandom);
		else sl = 8'($urandom_range(0, slot_cap[p] - 1));
		send_cmd(c, p, k[46:31], k[30:0], sl);
	endtask

	initial begin
		int b0, b1, s0, s1;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_idx       = '0;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		calm          = 1'b0;
		slot_cap[0]   = 256;
		slot_cap[1]   = 256;
		foreach (sent_by_cmd[i]) sent_by_cmd[i] = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset sizes, key extremes on both pools
		send_cmd(CMD_INSERT, 1'b0, 16'hFFFF, 31'h7FFFFFFF, 8'd255);
		send_cmd(CMD_INSERT, 1'b1, 16'h0000, 31'h0, 8'd0);
		send_cmd(CMD_LOOKUP, 1'b0, 16'hFFFF, 31'h7FFFFFFF, 8'd0);
		send_cmd(CMD_LOOKUP, 1'b1, 16'h0000, 31'h0, 8'd0);
		send_cmd(CMD_LOOKUP, 1'b1, 16'hFFFF, 31'h7FFFFFFF, 8'd0);   // other pool: miss

		// one bucket, four slots: a single chain
		set_pools(1, 0, 4, 0);
		for (int i = 0; i < 4; i++) send_cmd(CMD_INSERT, 1'b0, 16'd1, 31'(i), 8'(i));
		send_cmd(CMD_INSERT, 1'b0, 16'd1, 31'd9, 8'd4);             // slot past count
		send_cmd(CMD_INSERT, 1'b1, 16'd1, 31'd9, 8'd0);             // zero slots
		send_cmd(CMD_LOOKUP, 1'b0, 16'd1, 31'd0, 8'd0);             // chain tail
		send_cmd(CMD_DELETE, 1'b0, 16'd1, 31'd1, 8'd0);             // middle
		send_cmd(CMD_DELETE, 1'b0, 16'd1, 31'd3, 8'd0);             // head
		send_cmd(CMD_LOOKUP, 1'b0, 16'd1, 31'd3, 8'd0);
		send_cmd(CMD_DELETE, 1'b0, 16'd7, 31'd7, 8'd0);             // absent key
		send_cmd(CMD_INSERT, 1'b0, 16'd2, 31'd2, 8'd2);             // slot already chained
		send_cmd(CMD_LOOKUP, 1'b0, 16'd1, 31'd0, 8'd0);
		send_cmd(CMD_LOOKUP, 1'b0, 16'd5, 31'd5, 8'd0);             // walk may loop
		send_cmd(CMD_CLEAR, 1'b1, 16'hFFFF, 31'h7FFFFFFF, 8'd255);
		send_cmd(CMD_LOOKUP, 1'b0, 16'd1, 31'd0, 8'd0);

		// sizes above the maximum saturate
		set_pools(1023, 1023, 511, 511);
		send_cmd(CMD_INSERT, 1'b0, 16'd3, 31'd600, 8'd255);
		send_cmd(CMD_LOOKUP, 1'b0, 16'd3, 31'd600, 8'd0);

		// random phases, small tables most of the time
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin b0 = 512; b1 = 1;   s0 = 256; s1 = 1;   end
				1: begin b0 = 0;   b1 = 3;   s0 = 8;   s1 = 16;  end
				2: begin b0 = 1023; b1 = 512; s0 = 511; s1 = 0;  end
				default: begin
					b0 = $urandom_range(1, 12);
					b1 = $urandom_range(0, 1023);
					s0 = $urandom_range(1, 32);
					s1 = $urandom_range(0, 511);
				end
			endcase
			set_pools(b0, b1, s0, s1);
			calm = (ph == 3);
			repeat (90) random_cmd();
		end
		calm = 1'b0;

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		$display("commands sent: %0d lookup, %0d insert, %0d delete, %0d clear",
			sent_by_cmd[CMD_LOOKUP], sent_by_cmd[CMD_INSERT],
			sent_by_cmd[CMD_DELETE], sent_by_cmd[CMD_CLEAR]);
		$display("table sizes from one to past the maximum, with stalls on both sides");
		if (fails == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end

endmodule

@@ files.f @@
rtl/chbi_pkg.sv
rtl/chained_hash_buffer_index.sv
bench/chbi_checker.sv
bench/tb_chained_hash_buffer_index.sv
